// ===== rtl/rhls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rhls_pkg;

  localparam int COMPONENT_BITS_DEF = 8;
  localparam int RESULT_BITS_DEF    = 16;

  // which component holds the maximum; ties go to red, then green
  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } max_sel_t;

endpackage
`default_nettype wire

// ===== rtl/rhls_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rhls_in_if #(parameter int CB = 8) ();
  logic          valid;
  logic          ready;
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhls_out_if #(parameter int RB = 16) ();
  logic          valid;
  logic          ready;
  logic [RB-1:0] hue;
  logic          hue_undefined;
  logic [RB-1:0] lightness;
  logic [RB-1:0] saturation;

  modport source (output valid, output hue, output hue_undefined, output lightness,
                  output saturation, input ready);
  modport sink   (input valid, input hue, input hue_undefined, input lightness,
                  input saturation, output ready);
endinterface
`default_nettype wire

// ===== rtl/rhls_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rhls_prep
  import rhls_pkg::*;
#(
  parameter int CB = COMPONENT_BITS_DEF,
  parameter int RB = RESULT_BITS_DEF,
  parameter int WW = RB + CB + 5
) (
  input  wire logic          clk,
  input  wire logic [2:0]    en,
  input  wire logic [CB-1:0] red,
  input  wire logic [CB-1:0] green,
  input  wire logic [CB-1:0] blue,
  output logic [WW-1:0]      hue_num,
  output logic [WW-1:0]      hue_den,
  output logic [WW-1:0]      sat_num,
  output logic [WW-1:0]      sat_den,
  output logic [RB+CB-1:0]   lit_num,
  output logic               gray
);

  localparam int NB = CB + 3;
  localparam logic [CB:0] CMAX   = (CB+1)'((1 << CB) - 1);
  localparam logic [CB:0] CMAX2  = (CB+1)'(2 * ((1 << CB) - 1));

  // stage A: extremes
  logic [CB-1:0] r_r, g_r, b_r, mx_r, mi_r;
  logic [CB-1:0] mx_nxt, mi_nxt;
  max_sel_t      sel_r, sel_nxt;

  always_comb begin
    mx_nxt = red;
    mi_nxt = red;
    if (green > mx_nxt) mx_nxt = green;
    if (blue > mx_nxt)  mx_nxt = blue;
    if (green < mi_nxt) mi_nxt = green;
    if (blue < mi_nxt)  mi_nxt = blue;
    if (red >= green && red >= blue) sel_nxt = SEL_RED;
    else if (green >= blue)          sel_nxt = SEL_GREEN;
    else                             sel_nxt = SEL_BLUE;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r   <= red;
      g_r   <= green;
      b_r   <= blue;
      mx_r  <= mx_nxt;
      mi_r  <= mi_nxt;
      sel_r <= sel_nxt;
    end
  end

  // stage B: sum, spread, sector numerator (sector*d, offset by 6d when negative)
  logic [CB-1:0] d_nxt, d_r;
  logic [CB:0]   sum_nxt, sum_r, den_nxt, den_r;
  logic [NB-1:0] d6, d2, d4, num_nxt, num_r;
  logic          gray_nxt, gray_r;

  always_comb begin
    d_nxt   = mx_r - mi_r;
    sum_nxt = {1'b0, mx_r} + {1'b0, mi_r};
    d2      = NB'(d_nxt) << 1;
    d4      = NB'(d_nxt) << 2;
    d6      = d4 + d2;
    den_nxt = (sum_nxt <= CMAX) ? sum_nxt : CMAX2 - sum_nxt;
    gray_nxt = (d_nxt == '0);
    case (sel_r)
      SEL_RED:   num_nxt = (g_r >= b_r) ? NB'(g_r - b_r) : d6 - NB'(b_r - g_r);
      SEL_GREEN: num_nxt = (b_r >= r_r) ? d2 + NB'(b_r - r_r) : d2 - NB'(r_r - b_r);
      SEL_BLUE:  num_nxt = (r_r >= g_r) ? d4 + NB'(r_r - g_r) : d4 - NB'(g_r - r_r);
      default:   num_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d_r    <= d_nxt;
      sum_r  <= sum_nxt;
      den_r  <= den_nxt;
      num_r  <= num_nxt;
      gray_r <= gray_nxt;
    end
  end

  // stage C: dividend and divisor for round(n/q) = floor((2n+q)/(2q));
  // lightness keeps floor((sum*RMAX + CMAX)/2), later divided by CMAX
  logic [WW-1:0] dw, d6w, sumw;
  logic [WW-1:0] hn_nxt, hd_nxt, sn_nxt, sd_nxt, ln_nxt;

  always_comb begin
    dw   = WW'(d_r);
    d6w  = (dw << 2) + (dw << 1);
    sumw = WW'(sum_r);
    ln_nxt = ((sumw << RB) - sumw + WW'(CMAX)) >> 1;
    if (gray_r) begin
      hn_nxt = '0;
      hd_nxt = WW'(1);
      sn_nxt = '0;
      sd_nxt = WW'(1);
    end else begin
      hn_nxt = (WW'(num_r) << (RB + 1)) + d6w;
      hd_nxt = d6w << 1;
      sn_nxt = (dw << (RB + 1)) - (dw << 1) + WW'(den_r);
      sd_nxt = WW'(den_r) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hue_num <= hn_nxt;
      hue_den <= hd_nxt;
      sat_num <= sn_nxt;
      sat_den <= sd_nxt;
      lit_num <= ln_nxt[RB+CB-1:0];
      gray    <= gray_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rhls_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rhls_div #(
  parameter int WW = 29,
  parameter int QW = 17
) (
  input  wire logic          clk,
  input  wire logic [QW-1:0] en,
  input  wire logic [WW-1:0] num,
  input  wire logic [WW-1:0] den,
  output logic [QW-1:0]      quo
);

  // restoring division, one quotient bit per stage, MSB first
  logic [WW-1:0] rem_r [QW-1];
  logic [WW-1:0] den_r [QW-1];
  logic [QW-1:0] q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [WW-1:0] rem_i, den_i, sh;
    logic [QW-1:0] q_i;
    logic [WW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_i = num;
      assign den_i = den;
      assign q_i   = '0;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign q_i   = q_r[k-1];
    end

    assign sh   = den_i << (QW - 1 - k);
    assign diff = {1'b0, rem_i} - {1'b0, sh};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        q_r[k] <= {q_i[QW-2:0], ~diff[WW]};
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= diff[WW] ? rem_i : diff[WW-1:0];
          den_r[k] <= den_i;
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule
`default_nettype wire

// ===== rtl/rgb_to_hls_converter_unit.sv =====
// Throughput: one item per cycle while the output accepts results; set by the two
// pipelined dividers for hue and saturation, one quotient bit per stage,
// running in lock step.
// Stages advance independently, so bubbles close up while the output stalls.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hls_converter_unit
  import rhls_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int RESULT_BITS    = RESULT_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rhls_in_if.sink     in_chan,
  rhls_out_if.source  out_chan
);

  localparam int CB = COMPONENT_BITS;
  localparam int RB = RESULT_BITS;
  localparam int WW = RB + CB + 5;
  localparam int QW = RB + 1;
  localparam int NV = QW + 3;
  localparam int YW = RB + CB;
  localparam int SH = RB + 2 * CB;
  localparam longint unsigned CMAX_L = (64'd1 << CB) - 64'd1;
  localparam longint unsigned RECIP  = ((64'd1 << SH) + CMAX_L - 64'd1) / CMAX_L;
  localparam logic [YW:0]     LIT_M  = (YW+1)'(RECIP);

  logic [NV-1:0] v_r, v_nxt;
  logic [NV:0]   rdy;

  always_comb begin
    rdy[NV] = out_chan.ready;
    for (int k = NV - 1; k >= 0; k--) begin
      rdy[k] = rdy[k+1] | ~v_r[k];
    end
    v_nxt = {v_r[NV-2:0], in_chan.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NV; k++) begin
        if (rdy[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  assign in_chan.ready = rdy[0];

  logic [WW-1:0] hue_num, hue_den, sat_num, sat_den;
  logic [YW-1:0] lit_num;
  logic          gray;

  rhls_prep #(.CB(CB), .RB(RB), .WW(WW)) u_prep (
    .clk     (clk),
    .en      (rdy[2:0]),
    .red     (in_chan.red),
    .green   (in_chan.green),
    .blue    (in_chan.blue),
    .hue_num (hue_num),
    .hue_den (hue_den),
    .sat_num (sat_num),
    .sat_den (sat_den),
    .lit_num (lit_num),
    .gray    (gray)
  );

  logic [QW-1:0] hue_q, sat_q;

  rhls_div #(.WW(WW), .QW(QW)) u_div_hue (
    .clk (clk), .en (rdy[NV-1:3]), .num (hue_num), .den (hue_den), .quo (hue_q)
  );
  rhls_div #(.WW(WW), .QW(QW)) u_div_sat (
    .clk (clk), .en (rdy[NV-1:3]), .num (sat_num), .den (sat_den), .quo (sat_q)
  );

  // lightness: divide by CMAX through an exact reciprocal multiply, then
  // delay to line up with the divider outputs
  logic [2*YW:0] lit_prod;
  logic [RB-1:0] lit_r [QW];

  assign lit_prod = lit_num * LIT_M;

  always_ff @(posedge clk) begin
    if (rdy[3]) lit_r[0] <= lit_prod[SH +: RB];
    for (int k = 1; k < QW; k++) begin
      if (rdy[k+3]) lit_r[k] <= lit_r[k-1];
    end
  end

  // gray flag rides alongside the divider stages
  logic [QW-1:0] und_r, und_nxt;
  assign und_nxt = {und_r[QW-2:0], gray};

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rdy[k+3]) und_r[k] <= und_nxt[k];
    end
  end

  // hue of a full turn wraps to zero by dropping the top quotient bit
  assign out_chan.valid         = v_r[NV-1];
  assign out_chan.hue           = hue_q[RB-1:0];
  assign out_chan.hue_undefined = und_r[QW-1];
  assign out_chan.lightness     = lit_r[QW-1];
  assign out_chan.saturation    = sat_q[RB-1:0];

`ifndef SYNTHESIS
  a_gray_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.hue_undefined |-> out_chan.saturation == '0)
    else $error("gray item with nonzero saturation");
  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.hue_undefined |-> out_chan.hue == '0)
    else $error("gray item with nonzero hue");
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    v_r == '0 |-> in_chan.ready)
    else $error("empty pipeline refuses an item");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> out_chan.valid && $stable(out_chan.lightness))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
